>>> hw/rtl/running_sample_statistics_macros.svh
// Assertion macros shared by the running sample statistics RTL.
`ifndef RUNNING_SAMPLE_STATISTICS_MACROS_SVH
`define RUNNING_SAMPLE_STATISTICS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition must hold in every cycle out of reset.
`define RSS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `RSS_ASSERT_IMPL(label, clk, rst, 1'b1, cond, msg)

`endif

>>> hw/rtl/rss_pkg.sv
// Types and constants shared by the running sample statistics block.
`default_nettype none

package rss_pkg;

   localparam int WORD_W         = 64;
   localparam int SAMPLE_W       = 16;
   localparam int STEP_W         = 7;
   localparam int MEAN_FRAC_BITS = 8;

   typedef logic [WORD_W-1:0]          word_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic signed [SAMPLE_W-1:0] value_type;
   typedef logic [16:0]                count_type;
   typedef logic [15:0]                spread_type;
   typedef logic signed [23:0]         mean_type;
   typedef logic [15:0]                root_type;

   localparam step_type DIV_STEPS  = step_type'(WORD_W);
   localparam step_type ROOT_STEPS = step_type'(WORD_W / 2);
   localparam word_type ROOT_FIRST = word_type'(1) << (WORD_W - 2);

   typedef struct packed {
      value_type sample;
      logic      last;
   } sample_type;

   typedef struct packed {
      count_type  count;
      value_type  smallest;
      value_type  largest;
      spread_type spread;
      mean_type   mean_q8;
      root_type   std_dev;
      logic       overflow;
   } result_type;

   // Operand loads of the shared iterative unit.
   typedef enum logic [2:0] {
      LOAD_NONE,
      LOAD_N_SUMSQ,
      LOAD_SUM_SQ,
      LOAD_N_N,
      LOAD_DIV_VAR,
      LOAD_ROOT,
      LOAD_DIV_MEAN
   } load_type;

   // Where a finished unit result is written.
   typedef enum logic [2:0] {
      SAVE_NONE,
      SAVE_NUMER,
      SAVE_SUB,
      SAVE_SD,
      SAVE_MEAN
   } save_type;

   typedef struct packed {
      logic     take;
      load_type load;
      logic     run;
      save_type save;
      logic     publish;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic out_blocked;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/rss_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
`default_nettype none

interface rss_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rss_datapath.sv
// Accumulators, shared multiply/divide/root unit and result register.
`default_nettype none
`include "running_sample_statistics_macros.svh"

module rss_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_COUNT   = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  rss_pkg::cmd_type    cmd,
   output rss_pkg::status_type status,
   input  rss_pkg::sample_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rss_pkg::result_type rsp_payload
);

   localparam int CountBits = $clog2(MAX_COUNT + 1);
   localparam int SumBits   = SAMPLE_BITS + CountBits;
   localparam int SqBits    = 2 * SAMPLE_BITS;
   localparam int SumSqBits = (SqBits + CountBits > rss_pkg::WORD_W) ?
                              rss_pkg::WORD_W : SqBits + CountBits;
   localparam int WordW     = rss_pkg::WORD_W;
   localparam logic [CountBits-1:0] CountLimit = CountBits'(MAX_COUNT);

   typedef enum logic [1:0] {
      MODE_MUL,
      MODE_DIV,
      MODE_ROOT
   } mode_type;

   // Run accumulators
   logic [CountBits-1:0]       count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [SumBits-1:0]  sum_ff, sum_in;
   logic [SumSqBits-1:0]       sumsq_ff, sumsq_in;
   logic                       ovf_ff, ovf_in;
   logic                       sq_pend_ff, sq_pend_in;
   logic [SqBits-1:0]          sq_ff;

   // Iterative unit
   rss_pkg::word_type          a_ff, a_in, b_ff, b_in, r_ff, r_in;
   rss_pkg::step_type          steps_ff, steps_in;
   mode_type                   mode_ff, mode_in;
   rss_pkg::word_type          numer_ff, numer_in;
   rss_pkg::root_type          sd_ff, sd_in;
   rss_pkg::mean_type          mean_ff, mean_in;

   // Result register
   logic                       out_valid_ff, out_valid_in;
   rss_pkg::result_type        out_ff, out_in;

   logic [SAMPLE_BITS-1:0]        x_raw;
   logic signed [SAMPLE_BITS-1:0] x_s;
   logic signed [SqBits-1:0]      sq_full;
   logic signed [SAMPLE_BITS:0]   spread_full;
   rss_pkg::word_type             sum_wide, smag, n_wide;
   logic                          sum_neg;
   logic [WordW:0]                rem_sh, rem_diff;
   logic                          rem_fit;
   rss_pkg::word_type             root_t;
   logic                          root_fit;

   generate
      if (SAMPLE_BITS <= rss_pkg::SAMPLE_W) begin : g_trunc
         assign x_raw = req_payload.sample[SAMPLE_BITS-1:0];
      end else begin : g_ext
         assign x_raw = {{(SAMPLE_BITS - rss_pkg::SAMPLE_W){1'b0}}, req_payload.sample};
      end
   endgenerate

   assign x_s         = signed'(x_raw);
   assign sq_full     = x_s * x_s;
   assign spread_full = (SAMPLE_BITS + 1)'(max_ff) - (SAMPLE_BITS + 1)'(min_ff);
   assign sum_neg     = sum_ff[SumBits-1];
   assign sum_wide    = rss_pkg::word_type'(sum_ff);
   assign smag        = sum_neg ? (rss_pkg::word_type'(0) - sum_wide) : sum_wide;
   assign n_wide      = rss_pkg::word_type'(count_ff);

   assign rem_sh   = {r_ff, a_ff[WordW-1]};
   assign rem_fit  = rem_sh >= {1'b0, b_ff};
   assign rem_diff = rem_sh - {1'b0, b_ff};
   assign root_t   = r_ff + b_ff;
   assign root_fit = a_ff >= root_t;

   assign status.unit_done   = (mode_ff == MODE_MUL) ? (b_ff == '0) : (steps_ff == '0);
   assign status.out_blocked = out_valid_ff & ~rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // Accumulation: the square is registered and added in the following cycle.
   always_comb begin
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      sumsq_in   = sumsq_ff;
      ovf_in     = ovf_ff;
      sq_pend_in = 1'b0;
      if (sq_pend_ff) begin
         sumsq_in = sumsq_ff + SumSqBits'(sq_ff);
      end
      if (cmd.take) begin
         if (count_ff == CountLimit) begin
            ovf_in = 1'b1;
         end else begin
            if (count_ff == '0) begin
               min_in = x_s;
               max_in = x_s;
            end else begin
               if (x_s < min_ff) min_in = x_s;
               if (x_s > max_ff) max_in = x_s;
            end
            sum_in     = sum_ff + SumBits'(x_s);
            count_in   = count_ff + CountBits'(1);
            sq_pend_in = 1'b1;
         end
      end
      if (cmd.publish) begin
         count_in = '0;
         min_in   = '0;
         max_in   = '0;
         sum_in   = '0;
         sumsq_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // Shared unit: shift-add multiply, restoring divide and bitwise square root.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      steps_in = steps_ff;
      mode_in  = mode_ff;
      case (cmd.load)
         rss_pkg::LOAD_N_SUMSQ: begin
            a_in    = rss_pkg::word_type'(sumsq_ff);
            b_in    = n_wide;
            r_in    = '0;
            mode_in = MODE_MUL;
         end
         rss_pkg::LOAD_SUM_SQ: begin
            a_in    = smag;
            b_in    = smag;
            r_in    = '0;
            mode_in = MODE_MUL;
         end
         rss_pkg::LOAD_N_N: begin
            a_in    = n_wide;
            b_in    = n_wide;
            r_in    = '0;
            mode_in = MODE_MUL;
         end
         rss_pkg::LOAD_DIV_VAR: begin
            a_in     = numer_ff;
            b_in     = r_ff;
            r_in     = '0;
            steps_in = rss_pkg::DIV_STEPS;
            mode_in  = MODE_DIV;
         end
         rss_pkg::LOAD_ROOT: begin
            // The quotient left in a_ff is the variance.
            b_in     = rss_pkg::ROOT_FIRST;
            r_in     = '0;
            steps_in = rss_pkg::ROOT_STEPS;
            mode_in  = MODE_ROOT;
         end
         rss_pkg::LOAD_DIV_MEAN: begin
            a_in     = smag << rss_pkg::MEAN_FRAC_BITS;
            b_in     = n_wide;
            r_in     = '0;
            steps_in = rss_pkg::DIV_STEPS;
            mode_in  = MODE_DIV;
         end
         default: begin
            if (cmd.run) begin
               case (mode_ff)
                  MODE_MUL: begin
                     if (b_ff[0]) r_in = r_ff + a_ff;
                     a_in = a_ff << 1;
                     b_in = b_ff >> 1;
                  end
                  MODE_DIV: begin
                     r_in     = rem_fit ? rem_diff[WordW-1:0] : rem_sh[WordW-1:0];
                     a_in     = {a_ff[WordW-2:0], rem_fit};
                     steps_in = steps_ff - rss_pkg::step_type'(1);
                  end
                  MODE_ROOT: begin
                     if (root_fit) begin
                        a_in = a_ff - root_t;
                        r_in = (r_ff >> 1) + b_ff;
                     end else begin
                        r_in = r_ff >> 1;
                     end
                     b_in     = b_ff >> 2;
                     steps_in = steps_ff - rss_pkg::step_type'(1);
                  end
                  default: begin
                     steps_in = '0;
                  end
               endcase
            end
         end
      endcase
   end

   always_comb begin
      numer_in = numer_ff;
      sd_in    = sd_ff;
      mean_in  = mean_ff;
      case (cmd.save)
         rss_pkg::SAVE_NUMER: numer_in = r_ff;
         rss_pkg::SAVE_SUB:   numer_in = numer_ff - r_ff;
         rss_pkg::SAVE_SD:    sd_in    = rss_pkg::root_type'(r_ff);
         rss_pkg::SAVE_MEAN: begin
            mean_in = rss_pkg::mean_type'(sum_neg ? (rss_pkg::word_type'(0) - a_ff) : a_ff);
         end
         default: begin
            numer_in = numer_ff;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_in       = out_ff;
      if (cmd.publish) begin
         out_valid_in     = 1'b1;
         out_in.count     = rss_pkg::count_type'(count_ff);
         out_in.smallest  = rss_pkg::value_type'(min_ff);
         out_in.largest   = rss_pkg::value_type'(max_ff);
         out_in.spread    = rss_pkg::spread_type'(spread_full);
         out_in.mean_q8   = mean_ff;
         out_in.std_dev   = sd_ff;
         out_in.overflow  = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         ovf_ff       <= 1'b0;
         sq_pend_ff   <= 1'b0;
         steps_ff     <= '0;
         mode_ff      <= MODE_MUL;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         ovf_ff       <= ovf_in;
         sq_pend_ff   <= sq_pend_in;
         steps_ff     <= steps_in;
         mode_ff      <= mode_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_full;
      a_ff     <= a_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      numer_ff <= numer_in;
      sd_ff    <= sd_in;
      mean_ff  <= mean_in;
      out_ff   <= out_in;
   end

   `RSS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CountLimit, "count above bound")
   `RSS_ASSERT_NEXT(a_publish_clears, clock, reset, cmd.publish, count_ff == '0 && out_valid_ff, "publish did not clear the run")
   `RSS_ASSERT_IMPL(a_square_counted, clock, reset, sq_pend_ff, count_ff != '0, "pending square without a counted item")

endmodule

`default_nettype wire

>>> hw/rtl/rss_controller.sv
// Sequencer for item intake and the end-of-run arithmetic.
`default_nettype none
`include "running_sample_statistics_macros.svh"

module rss_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_ready,
   input  rss_pkg::status_type status,
   output rss_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_ACCUM,
      S_DRAIN,
      S_MUL_NS,
      S_MUL_SS,
      S_MUL_NN,
      S_DIV_VAR,
      S_ROOT,
      S_DIV_MEAN,
      S_PUBLISH
   } state_type;

   state_type         state_ff, state_in;
   logic              loaded_ff, loaded_in;
   logic              is_op;
   rss_pkg::load_type load_sel;
   rss_pkg::save_type save_sel;
   state_type         op_next;

   // Per-step operand load, result destination and successor.
   always_comb begin
      is_op    = 1'b1;
      load_sel = rss_pkg::LOAD_NONE;
      save_sel = rss_pkg::SAVE_NONE;
      op_next  = S_PUBLISH;
      case (state_ff)
         S_MUL_NS: begin
            load_sel = rss_pkg::LOAD_N_SUMSQ;
            save_sel = rss_pkg::SAVE_NUMER;
            op_next  = S_MUL_SS;
         end
         S_MUL_SS: begin
            load_sel = rss_pkg::LOAD_SUM_SQ;
            save_sel = rss_pkg::SAVE_SUB;
            op_next  = S_MUL_NN;
         end
         S_MUL_NN: begin
            load_sel = rss_pkg::LOAD_N_N;
            op_next  = S_DIV_VAR;
         end
         S_DIV_VAR: begin
            load_sel = rss_pkg::LOAD_DIV_VAR;
            op_next  = S_ROOT;
         end
         S_ROOT: begin
            load_sel = rss_pkg::LOAD_ROOT;
            save_sel = rss_pkg::SAVE_SD;
            op_next  = S_DIV_MEAN;
         end
         S_DIV_MEAN: begin
            load_sel = rss_pkg::LOAD_DIV_MEAN;
            save_sel = rss_pkg::SAVE_MEAN;
            op_next  = S_PUBLISH;
         end
         default: begin
            is_op = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.load    = rss_pkg::LOAD_NONE;
      cmd.save    = rss_pkg::SAVE_NONE;
      case (state_ff)
         S_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // Lets the last square reach the sum of squares.
            state_in = S_MUL_NS;
         end
         S_PUBLISH: begin
            if (!status.out_blocked) begin
               cmd.publish = 1'b1;
               state_in    = S_ACCUM;
            end
         end
         default: begin
            if (is_op) begin
               if (!loaded_ff) begin
                  cmd.load  = load_sel;
                  loaded_in = 1'b1;
               end else if (!status.unit_done) begin
                  cmd.run = 1'b1;
               end else begin
                  cmd.save  = save_sel;
                  loaded_in = 1'b0;
                  state_in  = op_next;
               end
            end else begin
               state_in = S_ACCUM;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_ACCUM;
         loaded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
      end
   end

   `RSS_ASSERT_NEXT(a_last_ends_run, clock, reset, state_ff == S_ACCUM && req_valid && req_last, state_ff == S_DRAIN, "last item did not end the run")
   `RSS_ASSERT_NEXT(a_drain_to_mul, clock, reset, state_ff == S_DRAIN, state_ff == S_MUL_NS && !loaded_ff, "drain did not start the arithmetic")
   `RSS_ASSERT_IMPL(a_loaded_in_op, clock, reset, loaded_ff, state_ff != S_ACCUM && state_ff != S_DRAIN && state_ff != S_PUBLISH, "operand flag outside an arithmetic step")

endmodule

`default_nettype wire

>>> hw/rtl/running_sample_statistics.sv
// Running sample statistics: top level joining the controller and datapath.
//
// Samples arrive on req_ch, one item per cycle while ready is high; the item
// flagged last closes the run. Each run yields one item on rsp_ch with the
// count, minimum, maximum, range, Q8 mean, population standard deviation and
// an overflow flag. Items beyond MAX_COUNT are dropped and set the flag.
// Within a run the block takes one item every cycle. After the last item
// ready drops while one shared shift-add/divide/root unit works through the
// run, most of it the two 64-step divisions and the 32-step root.
// Ready rises again as the result appears. The result then sits in an
// output register, so a new run may start while the receiver stalls; a
// further result waits until that register empties. Reset clears all
// accumulators and the valid flag of the output register; no clearing pass.
`default_nettype none

module running_sample_statistics #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_COUNT   = 65536
) (
   input  logic          clock,
   input  logic          reset,
   rss_stream_if.sink    req_ch,
   rss_stream_if.source  rsp_ch
);

   rss_pkg::cmd_type    cmd;
   rss_pkg::status_type status;
   rss_pkg::sample_type req_payload;
   rss_pkg::result_type rsp_payload;
   logic                req_ready;
   logic                rsp_valid;

   assign req_payload    = req_ch.payload;
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

   rss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_payload.last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rss_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_COUNT   (MAX_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> verif/running_sample_statistics_checker.sv
// Checker for the running sample statistics block: predicts each run's result and compares it.
module running_sample_statistics_checker #(
   parameter int MAX_COUNT = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  rss_pkg::sample_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rss_pkg::result_type rsp_payload,
   output int                  mismatches,
   output int                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   rss_pkg::count_type  run_count;
   rss_pkg::value_type  run_low;
   rss_pkg::value_type  run_high;
   logic signed [32:0]  run_total;
   logic [46:0]         run_total_sq;
   logic                run_dropped;
   rss_pkg::result_type expected_stats[$];

   function automatic logic [31:0] floor_root(input logic [63:0] v);
      logic [31:0] r;
      logic [31:0] trial;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) r = trial;
      end
      return r;
   endfunction

   task automatic clear_run();
      run_count    = '0;
      run_low      = '0;
      run_high     = '0;
      run_total    = '0;
      run_total_sq = '0;
      run_dropped  = 1'b0;
   endtask

   // Folds one accepted sample into the run and queues a result when the run closes.
   task automatic fold_sample(input rss_pkg::sample_type s);
      longint              x;
      longint              t;
      logic [63:0]         n;
      logic [63:0]         smag;
      logic [63:0]         quot;
      logic [63:0]         mean;
      logic [63:0]         numer;
      logic [63:0]         variance;
      logic [31:0]         root;
      rss_pkg::result_type r;
      x = longint'(s.sample);
      if (run_count >= MAX_COUNT) begin
         run_dropped = 1'b1;
      end else begin
         if (run_count == 0) begin
            run_low  = s.sample;
            run_high = s.sample;
         end else begin
            if (s.sample < run_low) run_low = s.sample;
            if (s.sample > run_high) run_high = s.sample;
         end
         run_total    = run_total + 33'(x);
         run_total_sq = run_total_sq + 47'(x * x);
         run_count    = run_count + 1'b1;
      end
      if (s.last) begin
         t        = run_total;
         n        = 64'(run_count);
         smag     = (t < 0) ? -t : t;
         quot     = (smag << 8) / n;
         mean     = (t < 0) ? -quot : quot;
         // Both products wrap at 64 bits, as the difference is all that matters.
         numer    = n * 64'(run_total_sq) - smag * smag;
         variance = numer / (n * n);
         root     = floor_root(variance);
         r.count    = run_count;
         r.smallest = run_low;
         r.largest  = run_high;
         r.spread   = rss_pkg::spread_type'(run_high - run_low);
         r.mean_q8  = mean[23:0];
         r.std_dev  = root[15:0];
         r.overflow = run_dropped;
         expected_stats.push_back(r);
         clear_run();
      end
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rss_pkg::result_type want;
      if (reset) begin
         clear_run();
         expected_stats.delete();
         mismatches = 0;
      end else begin
         // The result side is checked first, so that a stray item cannot consume
         // an expectation queued at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatches++;
            end else begin
               want = expected_stats.pop_front();
               check_field("count", want.count, rsp_payload.count);
               check_field("smallest", want.smallest, rsp_payload.smallest);
               check_field("largest", want.largest, rsp_payload.largest);
               check_field("spread", want.spread, rsp_payload.spread);
               check_field("mean_q8", want.mean_q8, rsp_payload.mean_q8);
               check_field("std_dev", want.std_dev, rsp_payload.std_dev);
               check_field("overflow", want.overflow, rsp_payload.overflow);
            end
         end
         if (req_valid && req_ready) fold_sample(req_payload);
      end
      outstanding = expected_stats.size();
   end

endmodule

>>> verif/tb_running_sample_statistics.sv
// Testbench top for the running sample statistics block: stimulus, idling and verdict.
module tb_running_sample_statistics;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SAMPLES  = 65536;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_ITEMS  = 30;
   localparam int DRAIN_CYCLES = 300;
   localparam int N_DIRECTED   = 22;

   // Sample in the upper sixteen bits, last flag in the lowest bit.
   localparam logic [16:0] DIRECTED [N_DIRECTED] = '{
      {16'h0000, 1'b1}, {16'h8000, 1'b1}, {16'h7fff, 1'b1},
      {16'h8000, 1'b0}, {16'h7fff, 1'b1},
      {16'hffff, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b1},
      {16'h0001, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b1},
      {16'h0005, 1'b0}, {16'hfffd, 1'b0}, {16'h0007, 1'b0}, {16'hfff7, 1'b1},
      {16'h7fff, 1'b0}, {16'h7fff, 1'b0}, {16'h7fff, 1'b1},
      {16'h8000, 1'b0}, {16'h8000, 1'b0}, {16'h8000, 1'b0}, {16'h8000, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   mismatches;
   int   outstanding;

   rss_stream_if #(.payload_type(rss_pkg::sample_type)) req_ch ();
   rss_stream_if #(.payload_type(rss_pkg::result_type)) rsp_ch ();

   running_sample_statistics #(
      .SAMPLE_BITS(16),
      .MAX_COUNT  (MAX_SAMPLES)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   running_sample_statistics_checker #(
      .MAX_COUNT(MAX_SAMPLES)
   ) stats_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_payload(req_ch.payload),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_payload(rsp_ch.payload),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver stalls in bursts until the quiet phase, then takes every item.
   initial begin
      forever begin
         if (quiet) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic push_sample(input rss_pkg::value_type v, input logic is_last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= '{sample: v, last: is_last};
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Half full-range values, the rest extremes, values near zero and clusters around a per-run centre.
   function automatic rss_pkg::value_type pick_sample(input rss_pkg::value_type centre);
      case ($urandom_range(0, 9))
         0: return rss_pkg::value_type'(16'h8000);
         1: return rss_pkg::value_type'(16'h7fff);
         2, 3: return centre + rss_pkg::value_type'($urandom_range(0, 63))
                      - rss_pkg::value_type'(32);
         4: return rss_pkg::value_type'($urandom_range(0, 2)) - rss_pkg::value_type'(1);
         default: return rss_pkg::value_type'($urandom);
      endcase
   endfunction

   task automatic random_runs(input int target);
      int                 pushed;
      int                 len;
      rss_pkg::value_type centre;
      pushed = 0;
      while (pushed < target) begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16);
         centre = rss_pkg::value_type'($urandom);
         for (int k = 1; k <= len; k++) push_sample(pick_sample(centre), k == len);
         pushed += len;
      end
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) push_sample(DIRECTED[i][16:1], DIRECTED[i][0]);

      random_runs(RANDOM_ITEMS);

      quiet = 1'b1;
      random_runs(QUIET_ITEMS);

      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
